>>> rtl/exlex_pkg.sv
package exlex_pkg;

  // Offset counter width inside a text; start_res carries its low 16 bits.
  localparam int TEXT_LENGTH_BITS = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [3:0] {
    TAG_INT      = 4'd0,
    TAG_FLOAT    = 4'd1,
    TAG_IDENT    = 4'd2,
    TAG_LPAREN   = 4'd3,
    TAG_RPAREN   = 4'd4,
    TAG_ADD      = 4'd5,
    TAG_SUB      = 4'd6,
    TAG_MUL      = 4'd7,
    TAG_DIV      = 4'd8,
    TAG_EXP      = 4'd9,
    TAG_MINUS    = 4'd10,
    TAG_BADCHAR  = 4'd11,
    TAG_OVERFLOW = 4'd12,
    TAG_DONE     = 4'd13,
    TAG_NONE     = 4'd15
  } tag_t;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_INT   = 5'b00010,
    MODE_FRAC  = 5'b00100,
    MODE_IDENT = 5'b01000,
    MODE_ERROR = 5'b10000
  } mode_t;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [3:0]  tag;
    logic [15:0] start_res;
    logic [15:0] length;
    logic        last;
  } result_t;

  // Up to two results written into the queue in one cycle, a first.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    a;
    result_t    b;
  } push_t;

  function automatic logic ch_is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic ch_is_letter(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic ch_is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  // Single-character operator tag, TAG_NONE for anything else.
  function automatic tag_t ch_op(input logic [7:0] c, input logic unary);
    tag_t t;
    case (c)
      CH_LPAREN: t = TAG_LPAREN;
      CH_RPAREN: t = TAG_RPAREN;
      CH_PLUS:   t = TAG_ADD;
      CH_STAR:   t = TAG_MUL;
      CH_SLASH:  t = TAG_DIV;
      CH_CARET:  t = TAG_EXP;
      CH_DASH:   t = unary ? TAG_MINUS : TAG_SUB;
      default:   t = TAG_NONE;
    endcase
    return t;
  endfunction

  function automatic logic is_unary_ctx(input tag_t p);
    return (p == TAG_NONE) || (p == TAG_LPAREN) || (p == TAG_ADD) || (p == TAG_SUB) ||
           (p == TAG_MUL) || (p == TAG_DIV) || (p == TAG_EXP);
  endfunction

endpackage

>>> rtl/exlex_core.sv
module exlex_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              max_tokens_we,
  input  logic [15:0]       max_tokens_data,
  input  logic              accept,
  input  exlex_pkg::item_t  item,
  output exlex_pkg::push_t  push
);
  import exlex_pkg::*;

  logic [15:0]                 max_tokens;
  mode_t                       mode, mode_next;
  logic [TEXT_LENGTH_BITS-1:0] token_start, token_start_next;
  logic [TEXT_LENGTH_BITS-1:0] char_offset, char_offset_next;
  tag_t                        prev_tag, prev_tag_next;
  logic [15:0]                 token_count, token_count_next;
  logic [15:0]                 pend_len, pend_len_next;

  logic        is_dig, is_let, pending, ovf, flush_do, take, idle_go;
  tag_t        pend_tag, op_tag, prev1;
  logic [15:0] count1, grown;
  result_t     flush_res, r2;
  logic        r2_valid;

  always_comb begin
    is_dig = ch_is_digit(item.ch);
    is_let = ch_is_letter(item.ch);
    pending = (mode == MODE_INT) || (mode == MODE_FRAC) || (mode == MODE_IDENT);
    pend_tag = (mode == MODE_INT) ? TAG_INT : (mode == MODE_FRAC) ? TAG_FLOAT : TAG_IDENT;
    grown = (pend_len == 16'hFFFF) ? pend_len : pend_len + 16'd1;
    ovf = token_count >= max_tokens;

    flush_res.tag = ovf ? TAG_OVERFLOW : pend_tag;
    flush_res.start_res = 16'(token_start);
    flush_res.length = ovf ? 16'd0 : pend_len;
    flush_res.last = 1'b0;

    mode_next = mode;
    token_start_next = token_start;
    char_offset_next = char_offset;
    prev_tag_next = prev_tag;
    token_count_next = token_count;
    pend_len_next = pend_len;
    flush_do = 1'b0;
    take = 1'b0;
    idle_go = 1'b0;
    r2_valid = 1'b0;
    r2 = '0;
    count1 = token_count;
    prev1 = prev_tag;
    op_tag = TAG_NONE;

    if (accept) begin
      if (item.action == ACT_END) begin
        flush_do = pending;
        if (pending && !ovf) begin
          count1 = token_count + 16'd1;
        end
        r2_valid = 1'b1;
        r2.tag = TAG_DONE;
        r2.start_res = 16'(char_offset);
        r2.length = count1;
        mode_next = MODE_IDLE;
        token_start_next = '0;
        char_offset_next = '0;
        prev_tag_next = TAG_NONE;
        token_count_next = '0;
        pend_len_next = '0;
      end else begin
        char_offset_next = char_offset + 1'b1;
        case (mode)
          MODE_INT: begin
            if (is_dig) begin
              pend_len_next = grown;
            end else if (item.ch == CH_DOT) begin
              pend_len_next = grown;
              mode_next = MODE_FRAC;
            end else begin
              take = 1'b1;
            end
          end
          MODE_FRAC: begin
            if (is_dig) pend_len_next = grown;
            else take = 1'b1;
          end
          MODE_IDENT: begin
            if (is_dig || is_let) pend_len_next = grown;
            else take = 1'b1;
          end
          MODE_IDLE: idle_go = 1'b1;
          default: ;
        endcase

        if (take) begin
          flush_do = 1'b1;
          if (ovf) begin
            mode_next = MODE_ERROR;
          end else begin
            count1 = token_count + 16'd1;
            prev1 = pend_tag;
            token_count_next = count1;
            prev_tag_next = prev1;
            mode_next = MODE_IDLE;
            idle_go = 1'b1;
          end
        end

        // Character seen between tokens, after any flush above.
        if (idle_go) begin
          op_tag = ch_op(item.ch, is_unary_ctx(prev1));
          if (ch_is_space(item.ch)) begin
            // skip
          end else if (is_dig || is_let || item.ch == CH_UNDER) begin
            mode_next = is_dig ? MODE_INT : MODE_IDENT;
            token_start_next = char_offset;
            pend_len_next = 16'd1;
          end else if (op_tag != TAG_NONE) begin
            r2_valid = 1'b1;
            r2.start_res = 16'(char_offset);
            if (count1 >= max_tokens) begin
              r2.tag = TAG_OVERFLOW;
              r2.length = 16'd0;
              mode_next = MODE_ERROR;
            end else begin
              r2.tag = op_tag;
              r2.length = 16'd1;
              token_count_next = count1 + 16'd1;
              prev_tag_next = op_tag;
            end
          end else begin
            r2_valid = 1'b1;
            r2.tag = TAG_BADCHAR;
            r2.start_res = 16'(char_offset);
            r2.length = 16'd1;
            mode_next = MODE_ERROR;
          end
        end
      end
    end

    r2.last = 1'b1;
    push.cnt = {1'b0, flush_do} + {1'b0, r2_valid};
    push.a = flush_do ? flush_res : r2;
    push.a.last = !(flush_do && r2_valid);
    push.b = r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens <= 16'hFFFF;
      mode <= MODE_IDLE;
      token_start <= '0;
      char_offset <= '0;
      prev_tag <= TAG_NONE;
      token_count <= '0;
      pend_len <= '0;
    end else begin
      if (max_tokens_we) max_tokens <= max_tokens_data;
      mode <= mode_next;
      token_start <= token_start_next;
      char_offset <= char_offset_next;
      prev_tag <= prev_tag_next;
      token_count <= token_count_next;
      pend_len <= pend_len_next;
    end
  end

endmodule

>>> rtl/exlex_fifo.sv
module exlex_fifo (
  input  logic               clk,
  input  logic               rst,
  input  exlex_pkg::push_t   push,
  output logic               room,
  output logic               result_valid,
  input  logic               result_stall,
  output exlex_pkg::result_t result
);
  import exlex_pkg::*;

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_BITS-1:0] cnt;
  logic                     pop;

  assign result_valid = cnt != '0;
  assign result = mem[rd_ptr];
  assign pop = result_valid && !result_stall;
  // Keep space for the worst case of two results per word.
  assign room = cnt <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr] <= push.a;
    if (push.cnt == 2'd2) mem[wr_ptr + 1'b1] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push.cnt);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + FIFO_CNT_BITS'(push.cnt) - FIFO_CNT_BITS'(pop);
    end
  end

endmodule

>>> rtl/expression_lexer.sv
// Streaming lexer for arithmetic expressions. Send one character per word
// (action 0) and an end-of-text word (action 1); each word gives zero, one or
// two results in order, the final one marked by last, and end of text always
// gives a done result carrying the token count. A word is taken every cycle
// while item_stall is low; its results are registered in a four-entry queue
// and leave one per cycle while result_stall is low, a word with two results
// using two slots, and item_stall rises while fewer than two queue slots
// are free. Write max_tokens only between texts while the block is idle.
module expression_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               max_tokens_we,
  input  logic [15:0]        max_tokens_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  exlex_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output exlex_pkg::result_t result
);
  import exlex_pkg::*;

  logic  accept, room;
  push_t push;

  assign item_stall = !room;
  assign accept = item_valid && room;

  exlex_core u_core (
    .clk             (clk),
    .rst             (rst),
    .max_tokens_we   (max_tokens_we),
    .max_tokens_data (max_tokens_data),
    .accept          (accept),
    .item            (item),
    .push            (push)
  );

  exlex_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> accept) else $error("result written without a word");

  a_end_gives_done: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_END) |-> (push.cnt != 2'd0 && push.b.tag == TAG_DONE))
    else $error("end of text without done");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd1) |-> push.a.last) else $error("single result not marked last");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd2) |-> (!push.a.last && push.b.last))
    else $error("result pair marked wrong");

endmodule

>>> tb/testbench.sv
module testbench;
  import exlex_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        max_tokens_we = 1'b0;
  logic [15:0] max_tokens_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  expression_lexer u_dut (
    .clk             (clk),
    .rst             (rst),
    .max_tokens_we   (max_tokens_we),
    .max_tokens_data (max_tokens_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 2_000_000);
    $display("expression_lexer test failed");
    $finish;
  end

  // Directed script: a word, a known result, or a max_tokens write.
  typedef struct packed {
    logic        cfg;
    logic [15:0] cfg_val;
    item_t       w;
    logic        typed;
    result_t     want;
  } plan_row_t;

  result_t     tokens_due[$];
  result_t     step_out[$];
  logic [7:0]  text_buf[$];
  int          mismatches = 0;
  int          words_sent = 0;
  bit          calm = 1'b0;
  int          stall_run = 0;

  // Lexer state as the block should hold it
  mode_t                       lex_mode = MODE_IDLE;
  logic [TEXT_LENGTH_BITS-1:0] tok_start = '0;
  logic [TEXT_LENGTH_BITS-1:0] offset = '0;
  tag_t                        prev_tag = TAG_NONE;
  logic [15:0]                 tok_count = '0;
  logic [15:0]                 pend_len = '0;
  logic [15:0]                 max_tok = 16'hFFFF;

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void put_tok(input tag_t tg, input logic [15:0] s,
                                  input logic [15:0] l);
    step_out.push_back('{tag: tg, start_res: s, length: l, last: 1'b0});
  endfunction

  // Emit a token, or its overflow once the count is used up.
  function automatic bit emit_tok(input tag_t tg, input logic [15:0] s,
                                  input logic [15:0] l);
    if (tok_count >= max_tok) begin
      put_tok(TAG_OVERFLOW, s, 16'd0);
      lex_mode = MODE_ERROR;
      return 1'b0;
    end
    tok_count++;
    prev_tag = tg;
    put_tok(tg, s, l);
    return 1'b1;
  endfunction

  function automatic bit flush_tok();
    tag_t tg;
    case (lex_mode)
      MODE_INT:   tg = TAG_INT;
      MODE_FRAC:  tg = TAG_FLOAT;
      MODE_IDENT: tg = TAG_IDENT;
      default:    return 1'b1;
    endcase
    lex_mode = MODE_IDLE;
    return emit_tok(tg, tok_start[15:0], pend_len);
  endfunction

  function automatic void begin_tok(input mode_t m);
    lex_mode = m;
    tok_start = offset;
    pend_len = 16'd1;
  endfunction

  function automatic void grow_tok();
    if (pend_len != 16'hFFFF) pend_len++;
  endfunction

  function automatic void idle_char(input logic [7:0] c);
    tag_t tg;
    if (c == " " || c == "\t" || c == "\n") return;
    if (digit_ch(c)) begin
      begin_tok(MODE_INT);
      return;
    end
    if (alpha_ch(c) || c == "_") begin
      begin_tok(MODE_IDENT);
      return;
    end
    case (c)
      "(":     tg = TAG_LPAREN;
      ")":     tg = TAG_RPAREN;
      "+":     tg = TAG_ADD;
      "*":     tg = TAG_MUL;
      "/":     tg = TAG_DIV;
      "^":     tg = TAG_EXP;
      "-": begin
        if (prev_tag inside {TAG_NONE, TAG_LPAREN, TAG_ADD, TAG_SUB, TAG_MUL, TAG_DIV,
                             TAG_EXP})
          tg = TAG_MINUS;
        else
          tg = TAG_SUB;
      end
      default: begin
        put_tok(TAG_BADCHAR, offset[15:0], 16'd1);
        lex_mode = MODE_ERROR;
        return;
      end
    endcase
    void'(emit_tok(tg, offset[15:0], 16'd1));
  endfunction

  // Advance the lexer by one word; its results land in step_out.
  function automatic void lex_step(input item_t w);
    bit take;
    take = 1'b0;
    step_out.delete();
    if (w.action == ACT_END) begin
      if (lex_mode != MODE_ERROR) void'(flush_tok());
      put_tok(TAG_DONE, offset[15:0], tok_count);
      lex_mode = MODE_IDLE;
      tok_start = '0;
      offset = '0;
      prev_tag = TAG_NONE;
      tok_count = '0;
      pend_len = '0;
    end else begin
      case (lex_mode)
        MODE_INT: begin
          if (digit_ch(w.ch)) grow_tok();
          else if (w.ch == ".") begin
            grow_tok();
            lex_mode = MODE_FRAC;
          end else take = 1'b1;
        end
        MODE_FRAC: begin
          if (digit_ch(w.ch)) grow_tok();
          else take = 1'b1;
        end
        MODE_IDENT: begin
          if (digit_ch(w.ch) || alpha_ch(w.ch)) grow_tok();
          else take = 1'b1;
        end
        MODE_IDLE: idle_char(w.ch);
        default: ;
      endcase
      if (take && flush_tok()) idle_char(w.ch);
      offset = offset + 1'b1;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (tokens_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result tag %0d", result.tag));
      end else begin
        want = tokens_due.pop_front();
        if (result.tag !== want.tag)
          flag_mismatch($sformatf("tag %0d, want %0d", result.tag, want.tag));
        if (result.start_res !== want.start_res)
          flag_mismatch($sformatf("start %0d, want %0d", result.start_res, want.start_res));
        if (result.length !== want.length)
          flag_mismatch($sformatf("length %0d, want %0d", result.length, want.length));
        if (result.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", result.last, want.last));
      end
    end
  end

  // Output back-pressure in bursts of random length.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      result_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_run <= $urandom_range(0, 15);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_word(input item_t w, input bit typed, input result_t want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    lex_step(w);
    if (typed) tokens_due.push_back(want);
    else foreach (step_out[i]) tokens_due.push_back(step_out[i]);
    words_sent++;
  endtask

  // Drain, let the block settle, then write max_tokens.
  task automatic set_limit(input logic [15:0] val);
    item_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    max_tokens_we <= 1'b1;
    max_tokens_data <= val;
    @(posedge clk);
    max_tokens_we <= 1'b0;
    max_tok = val;
  endtask

  function automatic plan_row_t char_row(input logic act, input logic [7:0] c);
    plan_row_t r;
    r = '0;
    r.w.action = act;
    r.w.ch = c;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic act, input logic [7:0] c,
                                          input tag_t tg, input logic [15:0] s,
                                          input logic [15:0] l);
    plan_row_t r;
    r = char_row(act, c);
    r.typed = 1'b1;
    r.want = '{tag: tg, start_res: s, length: l, last: 1'b1};
    return r;
  endfunction

  function automatic plan_row_t limit_row(input logic [15:0] val);
    plan_row_t r;
    r = '0;
    r.cfg = 1'b1;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("A" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic void add_space();
    case ($urandom_range(0, 7))
      0:       text_buf.push_back(" ");
      1:       text_buf.push_back("\t");
      2:       text_buf.push_back("\n");
      default: ;
    endcase
  endfunction

  function automatic void add_operand(input int depth);
    if ($urandom_range(0, 3) == 0) text_buf.push_back("-");
    if ($urandom_range(0, 9) == 0) text_buf.push_back("-");
    case ($urandom_range(0, 4))
      0, 1: begin
        repeat ($urandom_range(1, 4)) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          text_buf.push_back(".");
          repeat ($urandom_range(0, 3)) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end
      2, 3: begin
        if ($urandom_range(0, 7) == 0) text_buf.push_back("_");
        else if ($urandom_range(0, 1) == 0) text_buf.push_back(8'("a" + $urandom_range(0, 25)));
        else text_buf.push_back(8'("A" + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 5)) text_buf.push_back(rand_alnum());
      end
      default: begin
        if (depth < 3) begin
          text_buf.push_back("(");
          add_space();
          add_expr(depth + 1);
          add_space();
          text_buf.push_back(")");
        end else begin
          text_buf.push_back(rand_alnum());
        end
      end
    endcase
  endfunction

  function automatic void add_expr(input int depth);
    int terms;
    terms = $urandom_range(1, 5);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        add_space();
        case ($urandom_range(0, 4))
          0:       text_buf.push_back("+");
          1:       text_buf.push_back("-");
          2:       text_buf.push_back("*");
          3:       text_buf.push_back("/");
          default: text_buf.push_back("^");
        endcase
        add_space();
      end
      add_operand(depth);
    end
  endfunction

  // One text: mostly a well-formed expression, sometimes corrupted, raw bytes or empty.
  task automatic send_text();
    int k;
    k = $urandom_range(0, 15);
    text_buf.delete();
    if (k == 1) begin
      repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom));
    end else if (k != 0) begin
      add_expr(0);
      if (k <= 4) text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
    end
    foreach (text_buf[i]) send_word('{action: ACT_CHAR, ch: text_buf[i]}, 1'b0, '0);
    send_word('{action: ACT_END, ch: 8'($urandom)}, 1'b0, '0);
  endtask

  initial begin : stimulus
    plan_row_t   script[$];
    logic [15:0] limits[6];
    int          goal;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    script = '{
      known_row(ACT_END,  8'h00, TAG_DONE, 16'd0, 16'd0),
      known_row(ACT_CHAR, "-", TAG_MINUS, 16'd0, 16'd1),
      known_row(ACT_CHAR, "-", TAG_SUB, 16'd1, 16'd1),
      known_row(ACT_CHAR, "(", TAG_LPAREN, 16'd2, 16'd1),
      char_row(ACT_CHAR, "_"),
      char_row(ACT_CHAR, "Z"),
      char_row(ACT_CHAR, "9"),
      char_row(ACT_CHAR, " "),
      char_row(ACT_CHAR, "0"),
      char_row(ACT_CHAR, "."),
      char_row(ACT_CHAR, "9"),
      char_row(ACT_CHAR, ")"),
      char_row(ACT_CHAR, "*"),
      char_row(ACT_CHAR, "a"),
      char_row(ACT_CHAR, "/"),
      char_row(ACT_CHAR, "^"),
      char_row(ACT_CHAR, "z"),
      char_row(ACT_CHAR, "\t"),
      char_row(ACT_CHAR, "+"),
      char_row(ACT_CHAR, "\n"),
      char_row(ACT_CHAR, "5"),
      char_row(ACT_END,  8'hFF),
      known_row(ACT_CHAR, 8'hFF, TAG_BADCHAR, 16'd0, 16'd1),
      char_row(ACT_CHAR, "1"),
      known_row(ACT_END,  8'h00, TAG_DONE, 16'd2, 16'd0),
      limit_row(16'd1),
      known_row(ACT_CHAR, "(", TAG_LPAREN, 16'd0, 16'd1),
      known_row(ACT_CHAR, "(", TAG_OVERFLOW, 16'd1, 16'd0),
      known_row(ACT_END,  8'h00, TAG_DONE, 16'd2, 16'd1)
    };
    foreach (script[i]) begin
      if (script[i].cfg) set_limit(script[i].cfg_val);
      else send_word(script[i].w, script[i].typed, script[i].want);
    end

    limits = '{16'hFFFF, 16'd1, 16'd2, 16'($urandom_range(3, 9)),
               16'($urandom_range(1, 65535)), 16'hFFFF};
    for (int p = 0; p < 6; p++) begin
      if (p == 5) calm = 1'b1;
      set_limit(limits[p]);
      goal = words_sent + 225;
      while (words_sent < goal) send_text();
    end

    item_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("expression_lexer test passed");
    end else begin
      $display("expression_lexer test failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/exlex_pkg.sv
rtl/exlex_core.sv
rtl/exlex_fifo.sv
rtl/expression_lexer.sv
tb/testbench.sv
